[src/lsfx_pkg.sv]
// shared types, constants and colour wheel for the led strip effect generator
// no dependencies

package lsfx_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_REVERSE_ORDER = 1'b0;

   localparam logic [1:0] MODE_CHASE   = 2'd0;
   localparam logic [1:0] MODE_ALT     = 2'd1;
   localparam logic [1:0] MODE_RAINBOW = 2'd2;

   localparam logic [2:0] PHASE_LAST = 3'd7;
   localparam int TAIL_LEN = 3;

   localparam logic [7:0] LEVEL_HEAD  = 8'd255;
   localparam logic [7:0] LEVEL_TAIL1 = 8'd175;
   localparam logic [7:0] LEVEL_TAIL2 = 8'd95;
   localparam logic [7:0] LEVEL_FULL  = 8'd255;

   localparam logic [7:0] WHEEL_SPLIT1 = 8'd85;
   localparam logic [7:0] WHEEL_SPLIT2 = 8'd170;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   localparam rgb_type COLOUR_ORANGE = '{r: 8'd255, g: 8'd80, b: 8'd0};
   localparam rgb_type COLOUR_BLUE   = '{r: 8'd0, g: 8'd80, b: 8'd255};
   localparam rgb_type COLOUR_BLACK  = '{r: 8'd0, g: 8'd0, b: 8'd0};

   typedef struct packed {
      logic [2:0] pixel_position;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } pix_type;

   typedef struct packed {
      logic issue;
      logic last;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic step_en;
   } sts_type;

   function automatic rgb_type wheel(input logic [7:0] p);
      logic [7:0] q;
      logic [7:0] t;
      rgb_type c;
      if (p < WHEEL_SPLIT1) begin
         q = p;
      end else if (p < WHEEL_SPLIT2) begin
         q = p - WHEEL_SPLIT1;
      end else begin
         q = p - WHEEL_SPLIT2;
      end
      t = 8'({1'b0, q, 1'b0} + {2'b00, q});
      if (p < WHEEL_SPLIT1) begin
         c = '{r: t, g: LEVEL_FULL - t, b: 8'd0};
      end else if (p < WHEEL_SPLIT2) begin
         c = '{r: LEVEL_FULL - t, g: 8'd0, b: t};
      end else begin
         c = '{r: 8'd0, g: t, b: LEVEL_FULL - t};
      end
      return c;
   endfunction

endpackage

[src/lsfx_req_if.sv]
// frame tick request channel
// depends on nothing

interface lsfx_req_if;
   logic valid;
   logic ready;
   logic frame_tick;

   modport source (output valid, output frame_tick, input ready);
   modport sink (input valid, input frame_tick, output ready);
endinterface

[src/lsfx_rsp_if.sv]
// pixel result channel
// depends on nothing

interface lsfx_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] pixel_position;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_pixel;

   modport source (output valid, output pixel_position, output red, output green,
                   output blue, output last_pixel, input ready);
   modport sink (input valid, input pixel_position, input red, input green,
                 input blue, input last_pixel, output ready);
endinterface

[src/led_strip_effect_generator.sv]
// top level of the led strip effect generator: csr register, sequencer, colour pipeline
// depends on lsfx_pkg, lsfx_req_if, lsfx_rsp_if, lsfx_ctrl, lsfx_dpath
//
//   channel  direction  beat contents
//   req_bus  in         frame_tick
//   rsp_bus  out        pixel_position, red, green, blue, last_pixel
//   csr_*    in/out     apb register reverse_order at byte address 0
//
// a tick of one yields PIXEL_COUNT beats from the pixel counter, one per cycle while the
// output is not stalled, each through the three-stage colour pipeline
// the next tick is taken in the cycle the last pixel is issued
// a tick of zero is accepted and yields nothing
// rsp_bus.ready low with a beat held freezes the whole pipeline and the pixel counter
// synchronous reset clears effect state, sequencer and reverse_order

module led_strip_effect_generator
   import lsfx_pkg::*;
#(
   parameter int PIXEL_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   lsfx_req_if.sink              req_bus,
   lsfx_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IW = $clog2(PIXEL_COUNT);

   logic          reverse_ff, reverse_in;
   logic          csr_word;
   cmd_type       cmd;
   sts_type       sts;
   logic [IW-1:0] pix_idx;
   pix_type       pix;

   assign csr_pready = 1'b1;
   assign csr_word   = csr_paddr[CSR_ADDR_W-1];

   always_comb begin
      reverse_in = reverse_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_word == REG_REVERSE_ORDER)) begin
         reverse_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
      end else begin
         reverse_ff <= reverse_in;
      end
   end

   assign csr_prdata = (csr_word == REG_REVERSE_ORDER) ?
                       {{(CSR_DATA_W - 1){1'b0}}, reverse_ff} : '0;

   lsfx_ctrl #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_frame_tick (req_bus.frame_tick),
      .req_ready      (req_bus.ready),
      .sts            (sts),
      .cmd            (cmd),
      .pix_idx        (pix_idx)
   );

   lsfx_dpath #(
      .PIXEL_COUNT (PIXEL_COUNT)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .pix_idx       (pix_idx),
      .reverse_order (reverse_ff),
      .sts           (sts),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_pix       (pix)
   );

   assign rsp_bus.pixel_position = pix.pixel_position;
   assign rsp_bus.red            = pix.red;
   assign rsp_bus.green          = pix.green;
   assign rsp_bus.blue           = pix.blue;
   assign rsp_bus.last_pixel     = pix.last_pixel;

   a_issue_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> sts.step_en)
      else $error("pixel issued while pipeline stalled");

   a_tick_starts_frame: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.frame_tick) |=> !req_bus.ready)
      else $error("request taken during frame render");

   a_zero_tick_idle: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && !req_bus.frame_tick) |=> req_bus.ready)
      else $error("zero tick left sequencer busy");

endmodule

[src/lsfx_ctrl.sv]
// frame sequencer: takes ticks and walks the pixel counter
// depends on lsfx_pkg

module lsfx_ctrl
   import lsfx_pkg::*;
#(
   parameter int PIXEL_COUNT = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_frame_tick,
   output logic                           req_ready,
   input  sts_type                        sts,
   output cmd_type                        cmd,
   output logic [$clog2(PIXEL_COUNT)-1:0] pix_idx
);

   localparam int IW = $clog2(PIXEL_COUNT);
   localparam logic [IW-1:0] IDX_LAST = IW'(PIXEL_COUNT - 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_RENDER = 1'b1;

   logic          state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          last;
   logic          issue;
   logic          take_tick;

   assign last      = (cnt_ff == IDX_LAST);
   assign issue     = (state_ff == ST_RENDER) && sts.step_en;
   assign req_ready = (state_ff == ST_IDLE) || (issue && last);
   assign take_tick = req_valid && req_ready && req_frame_tick;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_tick) begin
               state_in = ST_RENDER;
               cnt_in   = '0;
            end
         end
         ST_RENDER: begin
            if (issue) begin
               if (last) begin
                  cnt_in   = '0;
                  state_in = take_tick ? ST_RENDER : ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign cmd.issue   = issue;
   assign cmd.last    = last;
   assign cmd.advance = issue && last;
   assign pix_idx     = cnt_ff;

endmodule

[src/lsfx_dpath.sv]
// effect state and three-stage colour pipeline: colour pick, scale multiply, divide by 255
// depends on lsfx_pkg

module lsfx_dpath
   import lsfx_pkg::*;
#(
   parameter int PIXEL_COUNT = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   input  logic [$clog2(PIXEL_COUNT)-1:0] pix_idx,
   input  logic                           reverse_order,
   output sts_type                        sts,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output pix_type                        rsp_pix
);

   localparam int IW = $clog2(PIXEL_COUNT);
   localparam logic [IW-1:0] IDX_LAST = IW'(PIXEL_COUNT - 1);
   localparam logic [IW:0]   COUNT_W  = (IW + 1)'(PIXEL_COUNT);
   localparam logic [IW:0]   TAIL_W   = (IW + 1)'(TAIL_LEN);

   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [15:0] s;
      s = x + (x >> 8) + 16'd1;
      return s[15:8];
   endfunction

   logic [IW-1:0] step_ff;
   logic [1:0]    mode_ff;
   logic [2:0]    phase_ff;

   logic          en;

   logic [IW:0]   lag;
   logic [7:0]    idx8;
   logic [7:0]    step8;
   logic [7:0]    chase_p;
   logic [7:0]    rainbow_p;
   logic [IW-1:0] mirror_idx;
   rgb_type       colour;
   logic [7:0]    level;

   logic          s1_valid_ff;
   rgb_type       s1_rgb_ff;
   logic [7:0]    s1_k_ff;
   logic [2:0]    s1_pos_ff;
   logic          s1_last_ff;

   logic          s2_valid_ff;
   logic [15:0]   s2_r_ff, s2_g_ff, s2_b_ff;
   logic [2:0]    s2_pos_ff;
   logic          s2_last_ff;

   logic          out_valid_ff;
   pix_type       out_ff;

   assign en = !out_valid_ff || rsp_ready;
   assign sts.step_en = en;

   // effect state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         mode_ff  <= MODE_CHASE;
         phase_ff <= '0;
      end else if (cmd.advance) begin
         if (step_ff == IDX_LAST) begin
            step_ff  <= '0;
            phase_ff <= (phase_ff == PHASE_LAST) ? 3'd0 : phase_ff + 3'd1;
            mode_ff  <= (mode_ff == MODE_CHASE) ? MODE_ALT :
                        (mode_ff == MODE_ALT) ? MODE_RAINBOW : MODE_CHASE;
         end else begin
            step_ff <= step_ff + IW'(1);
         end
      end
   end

   // colour pick
   always_comb begin
      if (pix_idx >= step_ff) begin
         lag = {1'b0, pix_idx} - {1'b0, step_ff};
      end else begin
         lag = {1'b0, pix_idx} + COUNT_W - {1'b0, step_ff};
      end
      idx8       = 8'(pix_idx);
      step8      = 8'(step_ff);
      chase_p    = {phase_ff, 5'd0} + (idx8 << 4);
      rainbow_p  = (step8 << 4) + (idx8 << 4) + (idx8 << 3);
      mirror_idx = IDX_LAST - pix_idx;
      colour     = COLOUR_BLACK;
      level      = LEVEL_FULL;
      priority case (mode_ff)
         MODE_CHASE: begin
            if (lag < TAIL_W) begin
               colour = wheel(chase_p);
               unique case (lag[1:0])
                  2'd0:    level = LEVEL_HEAD;
                  2'd1:    level = LEVEL_TAIL1;
                  2'd2:    level = LEVEL_TAIL2;
                  default: level = 8'd0;
               endcase
            end
         end
         MODE_ALT: begin
            colour = (pix_idx[0] ^ step_ff[0]) ? COLOUR_BLUE : COLOUR_ORANGE;
         end
         default: begin
            colour = wheel(rainbow_p);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_rgb_ff  <= colour;
         s1_k_ff    <= level;
         s1_pos_ff  <= reverse_order ? 3'(mirror_idx) : 3'(pix_idx);
         s1_last_ff <= cmd.last;

         s2_r_ff    <= 16'(s1_rgb_ff.r) * 16'(s1_k_ff);
         s2_g_ff    <= 16'(s1_rgb_ff.g) * 16'(s1_k_ff);
         s2_b_ff    <= 16'(s1_rgb_ff.b) * 16'(s1_k_ff);
         s2_pos_ff  <= s1_pos_ff;
         s2_last_ff <= s1_last_ff;

         out_ff.pixel_position <= s2_pos_ff;
         out_ff.red            <= div255(s2_r_ff);
         out_ff.green          <= div255(s2_g_ff);
         out_ff.blue           <= div255(s2_b_ff);
         out_ff.last_pixel     <= s2_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_pix   = out_ff;

endmodule
